>>> sv/sdsl_pkg.sv
// Package for the safe decode size limiter: register codes, reset values,
// sideband structs carried through the pipelines and a small min helper.
// No dependencies.
package sdsl_pkg;

    // configuration register indexes
    localparam logic REG_MAX_DIM = 1'b0;
    localparam logic REG_MAX_PIX = 1'b1;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;

    // reset values of the limits
    localparam logic [15:0] MAX_DIM_RESET = 16'd16384;
    localparam logic [31:0] MAX_PIX_RESET = 32'd268435456;

    // widths of the box fit division
    localparam int BOX_NUM_W = 50;
    localparam int BOX_DEN_W = 33;

    // sideband through the box fit divider
    typedef struct packed {
        logic [31:0] sw;
        logic [31:0] sh;
        logic [15:0] bw;
        logic [15:0] bh;
        logic        side_w;
    } t_box_side;

    // sideband through the limit dividers
    typedef struct packed {
        logic [31:0] w;
        logic [31:0] h;
        logic [63:0] area;
        logic        zero;
        logic        over_w;
        logic        over_h;
    } t_mid_side;

    // sideband through the square root stages
    typedef struct packed {
        t_mid_side   mid;
        logic [63:0] qa;
        logic [63:0] qb;
    } t_fin_side;

    function automatic logic [63:0] min64(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

>>> sv/sdsl_if.sv
// Channel interfaces of the safe decode size limiter: size request,
// size result and configuration write. Depends on sdsl_pkg.
interface sdsl_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_width;
    logic [31:0] source_height;
    logic [15:0] box_width;
    logic [15:0] box_height;

    modport source(output valid, source_width, source_height, box_width, box_height,
                   input ready);
    modport sink(input valid, source_width, source_height, box_width, box_height,
                 output ready);
endinterface

interface sdsl_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_width;
    logic [31:0] out_height;
    logic        scaled_for_safety;
    logic        size_valid;

    modport source(output valid, out_width, out_height, scaled_for_safety, size_valid,
                   input ready);
    modport sink(input valid, out_width, out_height, scaled_for_safety, size_valid,
                 output ready);
endinterface

interface sdsl_cfg_if import sdsl_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface

>>> sv/safe_decode_size_limiter_unit.sv
// Top level of the safe decode size limiter: limit registers, box fit,
// limit dividers, square roots and budget check. Depends on sdsl_pkg,
// sdsl_if, sdsl_div_pipe and sdsl_isqrt_pipe.
//
//   channel   dir   contents
//   i_req     in    source_width, source_height, box_width, box_height
//   o_rsp     out   out_width, out_height, scaled_for_safety, size_valid
//   i_cfg     in    addr (0 max_dimension, 1 max_pixels), data
//
// One request per cycle while the output is not stalled; the depth comes
// from the 50-stage box fit divider, the 64-stage limit dividers and the
// 32-stage square roots, one bit per stage.
// Synchronous active-low reset clears all valid bits and loads the limits.
// A result held at the output stalls the whole pipeline; nothing is lost.
// Limit writes are taken every cycle.
module safe_decode_size_limiter_unit import sdsl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    sdsl_req_if.sink   i_req,
    sdsl_rsp_if.source o_rsp,
    sdsl_cfg_if.sink   i_cfg
);

    logic [15:0] r_max_dim;
    logic [31:0] r_max_pix;
    logic        pipe_ce;
    logic        r_o_vld;

    // limit registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dim <= MAX_DIM_RESET;
            r_max_pix <= MAX_PIX_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.addr)
                REG_MAX_DIM: r_max_dim <= i_cfg.data[15:0];
                REG_MAX_PIX: r_max_pix <= i_cfg.data;
            endcase
        end
    end

    // whole pipeline moves unless a result waits
    assign pipe_ce     = !r_o_vld || o_rsp.ready;
    assign i_req.ready = pipe_ce;

    // stage A: box cross products
    logic        r_a_vld;
    logic [47:0] r_a_p1, r_a_p2;
    logic [31:0] r_a_sw, r_a_sh;
    logic [15:0] r_a_bw, r_a_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (pipe_ce) begin
            r_a_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ce) begin
            r_a_p1 <= 48'(i_req.box_width) * 48'(i_req.source_height);
            r_a_p2 <= 48'(i_req.box_height) * 48'(i_req.source_width);
            r_a_sw <= i_req.source_width;
            r_a_sh <= i_req.source_height;
            r_a_bw <= i_req.box_width;
            r_a_bh <= i_req.box_height;
        end
    end

    // stage B: rounded fit ratio operands
    logic                 r_b_vld;
    logic [BOX_NUM_W-1:0] r_b_num;
    logic [BOX_DEN_W-1:0] r_b_den;
    t_box_side            r_b_side;
    logic                 a_side_w;

    assign a_side_w = (r_a_p1 <= r_a_p2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (pipe_ce) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ce) begin
            if (a_side_w) begin
                r_b_num <= BOX_NUM_W'({r_a_p1, 1'b0}) + BOX_NUM_W'(r_a_sw);
                r_b_den <= {r_a_sw, 1'b0};
            end else begin
                r_b_num <= BOX_NUM_W'({r_a_p2, 1'b0}) + BOX_NUM_W'(r_a_sh);
                r_b_den <= {r_a_sh, 1'b0};
            end
            r_b_side <= '{sw: r_a_sw, sh: r_a_sh, bw: r_a_bw, bh: r_a_bh, side_w: a_side_w};
        end
    end

    // box fit divider
    logic                 box_vld;
    logic [BOX_NUM_W-1:0] box_num [1];
    logic [BOX_DEN_W-1:0] box_den [1];
    logic [BOX_NUM_W-1:0] box_quo [1];
    t_box_side            box_side;

    assign box_num[0] = r_b_num;
    assign box_den[0] = r_b_den;

    sdsl_div_pipe #(
        .NW    (BOX_NUM_W),
        .DW    (BOX_DEN_W),
        .SW    ($bits(t_box_side)),
        .LANES (1)
    ) u_box_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (pipe_ce),
        .i_vld   (r_b_vld),
        .i_num   (box_num),
        .i_den   (box_den),
        .i_side  (r_b_side),
        .o_vld   (box_vld),
        .o_quo   (box_quo),
        .o_side  (box_side)
    );

    // stage C: fitted size, each side at least 1; a zero box side keeps the source size
    logic        r_c_vld;
    logic [31:0] r_c_w, r_c_h;
    logic        r_c_zero;
    logic [31:0] c_w, c_h;

    always_comb begin
        c_w = box_side.sw;
        c_h = box_side.sh;
        if (box_side.bw != '0 && box_side.bh != '0) begin
            if (box_side.side_w) begin
                c_w = 32'(box_side.bw);
                c_h = box_quo[0][31:0];
            end else begin
                c_w = box_quo[0][31:0];
                c_h = 32'(box_side.bh);
            end
            if (c_w == '0) c_w = 32'd1;
            if (c_h == '0) c_h = 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (pipe_ce) begin
            r_c_vld <= box_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ce) begin
            r_c_w    <= c_w;
            r_c_h    <= c_h;
            r_c_zero <= (box_side.sw == '0) || (box_side.sh == '0);
        end
    end

    // stage D: products against the limits
    logic        r_d_vld;
    logic [63:0] r_d_hm, r_d_wm, r_d_wp, r_d_hp;
    t_mid_side   r_d_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (pipe_ce) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ce) begin
            r_d_hm          <= 64'(r_c_h) * 64'(r_max_dim);
            r_d_wm          <= 64'(r_c_w) * 64'(r_max_dim);
            r_d_wp          <= 64'(r_c_w) * 64'(r_max_pix);
            r_d_hp          <= 64'(r_c_h) * 64'(r_max_pix);
            r_d_side.w      <= r_c_w;
            r_d_side.h      <= r_c_h;
            r_d_side.area   <= 64'(r_c_w) * 64'(r_c_h);
            r_d_side.zero   <= r_c_zero;
            r_d_side.over_w <= (r_c_w > 32'(r_max_dim));
            r_d_side.over_h <= (r_c_h > 32'(r_max_dim));
        end
    end

    // limit dividers: h*md/w, w*md/h, w*mp/h, h*mp/w
    logic        lim_vld;
    logic [63:0] lim_num [4];
    logic [31:0] lim_den [4];
    logic [63:0] lim_quo [4];
    t_mid_side   lim_side;

    assign lim_num[0] = r_d_hm;
    assign lim_den[0] = r_d_side.w;
    assign lim_num[1] = r_d_wm;
    assign lim_den[1] = r_d_side.h;
    assign lim_num[2] = r_d_wp;
    assign lim_den[2] = r_d_side.h;
    assign lim_num[3] = r_d_hp;
    assign lim_den[3] = r_d_side.w;

    sdsl_div_pipe #(
        .NW    (64),
        .DW    (32),
        .SW    ($bits(t_mid_side)),
        .LANES (4)
    ) u_lim_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (pipe_ce),
        .i_vld   (r_d_vld),
        .i_num   (lim_num),
        .i_den   (lim_den),
        .i_side  (r_d_side),
        .o_vld   (lim_vld),
        .o_quo   (lim_quo),
        .o_side  (lim_side)
    );

    // square roots of the pixel budget ratios
    logic        sq_vld;
    logic [63:0] sq_x    [2];
    logic [31:0] sq_root [2];
    t_fin_side   sq_in_side;
    t_fin_side   sq_side;

    assign sq_x[0]    = lim_quo[2];
    assign sq_x[1]    = lim_quo[3];
    assign sq_in_side = '{mid: lim_side, qa: lim_quo[0], qb: lim_quo[1]};

    sdsl_isqrt_pipe #(
        .XW    (64),
        .SW    ($bits(t_fin_side)),
        .LANES (2)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (pipe_ce),
        .i_vld   (lim_vld),
        .i_x     (sq_x),
        .i_side  (sq_in_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage F: smallest scale per side, floor at 1
    logic        r_f_vld;
    logic [31:0] r_f_w, r_f_h;
    logic        r_f_shrunk, r_f_zero;
    logic [63:0] f_nw, f_nh;
    logic        f_over_p, f_shrunk;

    always_comb begin
        f_over_p = (sq_side.mid.area > 64'(r_max_pix));
        f_shrunk = sq_side.mid.over_w || sq_side.mid.over_h || f_over_p;
        f_nw     = 64'(sq_side.mid.w);
        f_nh     = 64'(sq_side.mid.h);
        if (sq_side.mid.over_w) begin
            f_nw = min64(f_nw, 64'(r_max_dim));
            f_nh = min64(f_nh, sq_side.qa);
        end
        if (sq_side.mid.over_h) begin
            f_nw = min64(f_nw, sq_side.qb);
            f_nh = min64(f_nh, 64'(r_max_dim));
        end
        if (f_over_p) begin
            f_nw = min64(f_nw, 64'(sq_root[0]));
            f_nh = min64(f_nh, 64'(sq_root[1]));
        end
        if (f_nw == '0) f_nw = 64'd1;
        if (f_nh == '0) f_nh = 64'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (pipe_ce) begin
            r_f_vld <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ce) begin
            r_f_w      <= f_shrunk ? f_nw[31:0] : sq_side.mid.w;
            r_f_h      <= f_shrunk ? f_nh[31:0] : sq_side.mid.h;
            r_f_shrunk <= f_shrunk;
            r_f_zero   <= sq_side.mid.zero;
        end
    end

    // stage G: final area
    logic        r_g_vld;
    logic [31:0] r_g_w, r_g_h;
    logic [63:0] r_g_area;
    logic        r_g_shrunk, r_g_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (pipe_ce) begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ce) begin
            r_g_area   <= 64'(r_f_w) * 64'(r_f_h);
            r_g_w      <= r_f_w;
            r_g_h      <= r_f_h;
            r_g_shrunk <= r_f_shrunk;
            r_g_zero   <= r_f_zero;
        end
    end

    // output register: budget check, zeros when unusable
    logic [31:0] r_o_w, r_o_h;
    logic        r_o_scaled, r_o_ok;
    logic        g_ok;

    assign g_ok = !r_g_zero && (r_g_area <= 64'(r_max_pix));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (pipe_ce) begin
            r_o_vld <= r_g_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_ce) begin
            r_o_w      <= g_ok ? r_g_w : '0;
            r_o_h      <= g_ok ? r_g_h : '0;
            r_o_scaled <= g_ok && r_g_shrunk;
            r_o_ok     <= g_ok;
        end
    end

    assign o_rsp.valid             = r_o_vld;
    assign o_rsp.out_width         = r_o_w;
    assign o_rsp.out_height        = r_o_h;
    assign o_rsp.scaled_for_safety = r_o_scaled;
    assign o_rsp.size_valid        = r_o_ok;

endmodule

>>> sv/sdsl_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one valid and one sideband word. No package dependencies.
module sdsl_div_pipe #(
    parameter int NW    = 64,
    parameter int DW    = 32,
    parameter int SW    = 1,
    parameter int LANES = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num [LANES],
    input  logic [DW-1:0] i_den [LANES],
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [NW-1:0] o_quo [LANES],
    output logic [SW-1:0] o_side
);

    logic [NW-1:0] r_acc  [NW][LANES];
    logic [DW-1:0] r_rem  [NW][LANES];
    logic [DW-1:0] r_den  [NW][LANES];
    logic [SW-1:0] r_side [NW];
    logic          r_vld  [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [NW-1:0] acc_in  [LANES];
        logic [DW-1:0] rem_in  [LANES];
        logic [DW-1:0] den_in  [LANES];
        logic [SW-1:0] side_in;
        logic          vld_in;
        logic [DW:0]   t       [LANES];
        logic [DW:0]   diff    [LANES];
        logic          ge      [LANES];

        // stage input: ports for the first stage, previous registers otherwise
        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    acc_in[l] = i_num[l];
                    rem_in[l] = '0;
                    den_in[l] = i_den[l];
                end
                side_in = i_side;
                vld_in  = i_vld;
            end
        end else begin : g_next
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    acc_in[l] = r_acc[k-1][l];
                    rem_in[l] = r_rem[k-1][l];
                    den_in[l] = r_den[k-1][l];
                end
                side_in = r_side[k-1];
                vld_in  = r_vld[k-1];
            end
        end

        // trial subtract of the divisor
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                t[l]    = {rem_in[l], acc_in[l][NW-1]};
                diff[l] = t[l] - {1'b0, den_in[l]};
                ge[l]   = (t[l] >= {1'b0, den_in[l]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                for (int l = 0; l < LANES; l++) begin
                    r_acc[k][l] <= {acc_in[l][NW-2:0], ge[l]};
                end
                r_side[k] <= side_in;
            end
        end

        // remainder and divisor are not needed past the last stage
        if (k < NW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    for (int l = 0; l < LANES; l++) begin
                        r_rem[k][l] <= ge[l] ? diff[l][DW-1:0] : t[l][DW-1:0];
                        r_den[k][l] <= den_in[l];
                    end
                end
            end
        end
    end

    assign o_vld  = r_vld[NW-1];
    assign o_side = r_side[NW-1];
    assign o_quo  = r_acc[NW-1];

endmodule

>>> sv/sdsl_isqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, several lanes
// sharing one valid and one sideband word. No package dependencies.
module sdsl_isqrt_pipe #(
    parameter int XW    = 64,
    parameter int SW    = 1,
    parameter int LANES = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_ce,
    input  logic            i_vld,
    input  logic [XW-1:0]   i_x    [LANES],
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [XW/2-1:0] o_root [LANES],
    output logic [SW-1:0]   o_side
);

    localparam int RW = XW / 2;

    logic [XW-1:0] r_x    [RW][LANES];
    logic [RW+1:0] r_rem  [RW][LANES];
    logic [RW-1:0] r_root [RW][LANES];
    logic [SW-1:0] r_side [RW];
    logic          r_vld  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [XW-1:0] x_in    [LANES];
        logic [RW+1:0] rem_in  [LANES];
        logic [RW-1:0] root_in [LANES];
        logic [SW-1:0] side_in;
        logic          vld_in;
        logic [RW+1:0] t       [LANES];
        logic [RW+1:0] trial   [LANES];
        logic          ge      [LANES];

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    x_in[l]    = i_x[l];
                    rem_in[l]  = '0;
                    root_in[l] = '0;
                end
                side_in = i_side;
                vld_in  = i_vld;
            end
        end else begin : g_next
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    x_in[l]    = r_x[k-1][l];
                    rem_in[l]  = r_rem[k-1][l];
                    root_in[l] = r_root[k-1][l];
                end
                side_in = r_side[k-1];
                vld_in  = r_vld[k-1];
            end
        end

        // bring down two bits, try root*4+1
        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                t[l]     = {rem_in[l][RW-1:0], x_in[l][XW-1:XW-2]};
                trial[l] = {root_in[l], 2'b01};
                ge[l]    = (t[l] >= trial[l]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                for (int l = 0; l < LANES; l++) begin
                    r_root[k][l] <= {root_in[l][RW-2:0], ge[l]};
                end
                r_side[k] <= side_in;
            end
        end

        if (k < RW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    for (int l = 0; l < LANES; l++) begin
                        r_x[k][l]   <= {x_in[l][XW-3:0], 2'b00};
                        r_rem[k][l] <= ge[l] ? (t[l] - trial[l]) : t[l];
                    end
                end
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_side = r_side[RW-1];
    assign o_root = r_root[RW-1];

endmodule

>>> sv/sdsl_checker.sv
// Port-level checks for the safe decode size limiter and the bind that
// attaches them to safe_decode_size_limiter_unit. No package dependencies.
module sdsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_req_ready,
    input logic        i_cfg_ready,
    input logic        i_rsp_valid,
    input logic        i_rsp_ready,
    input logic [31:0] i_out_width,
    input logic [31:0] i_out_height,
    input logic        i_scaled,
    input logic        i_size_valid
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_out_width)
            && $stable(i_out_height) && $stable(i_scaled) && $stable(i_size_valid))
        else $error("result changed while stalled");

    // unusable result is all zeros
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_size_valid |-> i_out_width == '0 && i_out_height == '0
            && !i_scaled)
        else $error("invalid result not zero");

    // usable result has both sides nonzero
    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_size_valid |-> i_out_width != '0 && i_out_height != '0)
        else $error("valid result with zero side");

    // requests move exactly when the output can move
    a_req_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_ready == (!i_rsp_valid || i_rsp_ready))
        else $error("request ready does not follow output stall");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("config port not ready");

endmodule

bind safe_decode_size_limiter_unit sdsl_checker u_sdsl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_cfg_ready  (i_cfg.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_out_width  (o_rsp.out_width),
    .i_out_height (o_rsp.out_height),
    .i_scaled     (o_rsp.scaled_for_safety),
    .i_size_valid (o_rsp.size_valid)
);
